// ===== design/hcma_pkg.sv =====
// hcma_pkg: shared constants and types of the hall-code-to-mirror-angle pipeline
// used by every module in this folder; depends on nothing

package hcma_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CODE_LIMIT = 1000;
    localparam int ADDR_W     = 3;
    localparam logic [63:0] DISC_EPS =
        64'((((65'd1 << (2 * FRAC_BITS)) + 65'd50000) / 65'd100000));

    // divider geometry, shared by the normalizing and the root dividers, and the square-root step count
    localparam int DIV_W     = 60;
    localparam int DIV_DEN_W = 34;
    localparam int SQ_STEPS  = 32;

    typedef enum logic [ADDR_W-1:0] {
        REG_LENGTH_OFFSET = 3'd0,
        REG_LENGTH_SCALE  = 3'd1,
        REG_COEF_A        = 3'd2,
        REG_COEF_B        = 3'd3,
        REG_COEF_C        = 3'd4,
        REG_TAKE_LEFT     = 3'd5,
        REG_ANGLE_SCALE   = 3'd6,
        REG_ANGLE_OFFSET  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] length_offset;
        logic signed [31:0] length_scale;
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic               take_left_root;
        logic signed [31:0] angle_scale;
        logic signed [31:0] angle_offset;
    } cfg_t;

    // flags that ride with every item through the pipe
    typedef struct packed {
        logic oor;
        logic fault;
    } flags_t;

    // side payload of the long units: negative-discriminant bit above the flags
    localparam int SIDE_W = $bits(flags_t) + 1;

    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        logic signed [31:0] r;
        if (v > 96'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -96'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== design/hall_code_to_mirror_angle_unit.sv =====
// hall_code_to_mirror_angle_unit: top level of the hall code to mirror angle pipeline
// depends on hcma_pkg, hcma_divider and hcma_sqrt
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  command  | start / busy          | sensor_code
//  config   | cfg_valid / cfg_ready | cfg_addr, cfg_data
//  result   | done (one cycle)      | angle, code_out_of_range,
//           |                       | no_real_root, divide_fault
//
//  one code per cycle; the code passes through 162 register stages, set by the
//  normalizing divider and the root divider (61 stages each), the 33-stage
//  square root, and seven single stages
//  busy is always low and cfg_ready always high; the receiver cannot stall,
//  so results leave on done without back pressure
//  reset clears valid bits and loads register defaults

module hall_code_to_mirror_angle_unit
    import hcma_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [9:0]         sensor_code,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ADDR_W-1:0]  cfg_addr,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] angle,
    output logic               code_out_of_range,
    output logic               no_real_root,
    output logic               divide_fault
);

    cfg_t cfg_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.length_offset  <= '0;
            cfg_reg.length_scale   <= 32'sd1 <<< FRAC_BITS;
            cfg_reg.coef_a         <= 32'sd1 <<< FRAC_BITS;
            cfg_reg.coef_b         <= '0;
            cfg_reg.coef_c         <= '0;
            cfg_reg.take_left_root <= 1'b0;
            cfg_reg.angle_scale    <= 32'sd1 <<< FRAC_BITS;
            cfg_reg.angle_offset   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_LENGTH_OFFSET: cfg_reg.length_offset  <= cfg_data;
                REG_LENGTH_SCALE:  cfg_reg.length_scale   <= cfg_data;
                REG_COEF_A:        cfg_reg.coef_a         <= cfg_data;
                REG_COEF_B:        cfg_reg.coef_b         <= cfg_data;
                REG_COEF_C:        cfg_reg.coef_c         <= cfg_data;
                REG_TAKE_LEFT:     cfg_reg.take_left_root <= cfg_data[0];
                REG_ANGLE_SCALE:   cfg_reg.angle_scale    <= cfg_data;
                REG_ANGLE_OFFSET:  cfg_reg.angle_offset   <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: numerator of y = (h*ONE - off)*ONE / ls, plus flags
    logic                   s1_vld_reg;
    logic signed [DIV_W-1:0] s1_num_reg;
    flags_t                 s1_flg_reg;
    logic signed [43:0]     h_shift;

    assign h_shift = 44'(sensor_code) <<< FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_num_reg       <= DIV_W'(h_shift - 44'(cfg_reg.length_offset)) <<< FRAC_BITS;
        s1_flg_reg.oor   <= sensor_code > 10'(CODE_LIMIT);
        s1_flg_reg.fault <= (cfg_reg.length_scale == 0) || (cfg_reg.coef_a == 0);
    end

    // normalizing divider; a zero length_scale is replaced by one and sets the fault flag
    logic                        y_vld;
    logic signed [DIV_W-1:0]     y_quo;
    logic [SIDE_W-1:0]           y_side;
    flags_t                      y_flg;
    logic signed [DIV_DEN_W-1:0] ls_den;

    assign ls_den = cfg_reg.length_scale == 0 ? 34'sd1 : DIV_DEN_W'(cfg_reg.length_scale);

    hcma_divider u_ydiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_vld_reg),
        .num      (s1_num_reg),
        .den      (ls_den),
        .side_in  ({1'b0, s1_flg_reg}),
        .out_valid(y_vld),
        .quo      (y_quo),
        .side_out (y_side)
    );

    assign y_flg = flags_t'(y_side[SIDE_W-2:0]);

    // stage 2: cy = sat(c + sat(y))
    logic               s2_vld_reg;
    logic signed [31:0] s2_cy_reg;
    flags_t             s2_flg_reg;
    logic signed [31:0] y_sat;

    assign y_sat = sat32(96'(y_quo));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= y_vld;
    end

    always_ff @(posedge clk)
    begin
        s2_cy_reg  <= sat32(96'(cfg_reg.coef_c) + 96'(y_sat));
        s2_flg_reg <= y_flg;
    end

    // stage 3: products b*b and a*cy, full 64-bit results
    logic               s3_vld_reg;
    logic [63:0]        s3_p_reg;
    logic signed [63:0] s3_q_reg;
    flags_t             s3_flg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_p_reg   <= 64'(cfg_reg.coef_b) * 64'(cfg_reg.coef_b);
        s3_q_reg   <= 64'(cfg_reg.coef_a) * 64'(s2_cy_reg);
        s3_flg_reg <= s2_flg_reg;
    end

    // stage 4: discriminant magnitude and sign
    logic        s4_vld_reg;
    logic [63:0] s4_mag_reg;
    logic        s4_neg_reg;
    flags_t      s4_flg_reg;
    logic [63:0] qm;
    logic [63:0] q4;
    logic [64:0] psum;
    logic [63:0] mag_c;
    logic        neg_c;

    always_comb
    begin
        qm   = s3_q_reg[63] ? 64'(-s3_q_reg) : 64'(s3_q_reg);
        q4   = (qm > (64'hffff_ffff_ffff_ffff >> 2)) ? 64'hffff_ffff_ffff_ffff : qm << 2;
        psum = {1'b0, s3_p_reg} + {1'b0, q4};
        neg_c = 1'b0;
        if (s3_q_reg > 0)
        begin
            if (s3_p_reg >= q4)
            begin
                mag_c = s3_p_reg - q4;
            end
            else
            begin
                mag_c = q4 - s3_p_reg;
                neg_c = 1'b1;
            end
        end
        else
        begin
            mag_c = psum[64] ? 64'hffff_ffff_ffff_ffff : psum[63:0];
        end
        if (mag_c < DISC_EPS)
        begin
            mag_c = '0;
            neg_c = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else
            s4_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_mag_reg <= mag_c;
        s4_neg_reg <= neg_c;
        s4_flg_reg <= s3_flg_reg;
    end

    // square root; the negative case rides along and ignores the root
    logic              sq_vld;
    logic [31:0]       sq_root;
    logic [SIDE_W-1:0] sq_side;
    logic              sq_neg;
    flags_t            sq_flg;

    hcma_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s4_vld_reg),
        .rad      (s4_mag_reg),
        .side_in  ({s4_neg_reg, s4_flg_reg}),
        .out_valid(sq_vld),
        .root     (sq_root),
        .side_out (sq_side)
    );

    assign sq_neg = sq_side[SIDE_W-1];
    assign sq_flg = flags_t'(sq_side[SIDE_W-2:0]);

    // stage 5: both root numerators, (-b +/- s) * ONE
    logic               s5_vld_reg;
    logic signed [50:0] s5_n1_reg;
    logic signed [50:0] s5_n2_reg;
    logic               s5_neg_reg;
    flags_t             s5_flg_reg;
    logic signed [34:0] s_eff;
    logic signed [34:0] nb;

    assign s_eff = sq_neg ? 35'sd0 : $signed({3'b000, sq_root});
    assign nb    = -35'(cfg_reg.coef_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else
            s5_vld_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        s5_n1_reg  <= 51'(nb + s_eff) <<< FRAC_BITS;
        s5_n2_reg  <= 51'(nb - s_eff) <<< FRAC_BITS;
        s5_neg_reg <= sq_neg;
        s5_flg_reg <= sq_flg;
    end

    // two root dividers in parallel, denominator 2a
    logic signed [DIV_DEN_W-1:0] a2;
    logic                        r1_vld;
    logic                        r2_vld;
    logic signed [DIV_W-1:0]     r1_quo;
    logic signed [DIV_W-1:0]     r2_quo;
    logic [SIDE_W-1:0]           r1_side;
    logic [SIDE_W-1:0]           r2_side;

    assign a2 = cfg_reg.coef_a == 0 ? 34'sd2 : DIV_DEN_W'(cfg_reg.coef_a) <<< 1;

    hcma_divider u_r1div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s5_vld_reg),
        .num      (DIV_W'(s5_n1_reg)),
        .den      (a2),
        .side_in  ({s5_neg_reg, s5_flg_reg}),
        .out_valid(r1_vld),
        .quo      (r1_quo),
        .side_out (r1_side)
    );

    hcma_divider u_r2div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s5_vld_reg),
        .num      (DIV_W'(s5_n2_reg)),
        .den      (a2),
        .side_in  ({s5_neg_reg, s5_flg_reg}),
        .out_valid(r2_vld),
        .quo      (r2_quo),
        .side_out (r2_side)
    );

    // stage 6: pick root, multiply by angle_scale
    logic               s6_vld_reg;
    logic signed [63:0] s6_prod_reg;
    logic signed [31:0] s6_equal_reg;
    logic               s6_eq_reg;
    logic               s6_neg_reg;
    flags_t             s6_flg_reg;
    logic signed [31:0] r_pick;

    assign r_pick = sat32(96'(cfg_reg.take_left_root ? r1_quo : r2_quo));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_vld_reg <= 1'b0;
        else
            s6_vld_reg <= r1_vld;
    end

    always_ff @(posedge clk)
    begin
        s6_prod_reg  <= 64'(r_pick) * 64'(cfg_reg.angle_scale);
        s6_equal_reg <= sat32(96'(r1_quo));
        s6_eq_reg    <= r1_quo == r2_quo;
        s6_neg_reg   <= r1_side[SIDE_W-1];
        s6_flg_reg   <= flags_t'(r1_side[SIDE_W-2:0]);
    end

    // stage 7: truncating shift toward zero, offset, saturate, output register
    logic signed [63:0] prod_sh;
    logic signed [63:0] bias;

    assign bias    = s6_prod_reg[63] ? (64'sd1 <<< FRAC_BITS) - 64'sd1 : 64'sd0;
    assign prod_sh = (s6_prod_reg + bias) >>> FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= s6_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        code_out_of_range <= s6_flg_reg.oor;
        divide_fault      <= s6_flg_reg.fault;
        no_real_root      <= s6_neg_reg && !s6_flg_reg.fault;
        if (s6_flg_reg.fault)
            angle <= '0;
        else if (s6_eq_reg)
            angle <= s6_equal_reg;
        else
            angle <= sat32(96'(prod_sh) + 96'(cfg_reg.angle_offset));
    end

`ifndef SYNTHESIS
    // the two root dividers run in lockstep
    a_root_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        r1_vld == r2_vld)
        else $error("root dividers out of step");

    // a fault result never reports a missing real root
    a_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_fault |-> !no_real_root && angle == 0)
        else $error("fault result not cleared");

    // a negative discriminant gives equal roots, so the angle is taken unscaled
    a_neg_equal: assert property (@(posedge clk) disable iff (!rst_n)
        s6_vld_reg && s6_neg_reg |-> s6_eq_reg)
        else $error("negative discriminant with unequal roots");
`endif

endmodule

// ===== design/hcma_divider.sv =====
// hcma_divider: pipelined restoring signed divider, one quotient bit per stage
// depends on hcma_pkg; truncates toward zero, carries a side payload along

module hcma_divider
    import hcma_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [DIV_W-1:0]     num,
    input  logic signed [DIV_DEN_W-1:0] den,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic signed [DIV_W-1:0]     quo,
    output logic [SIDE_W-1:0]           side_out
);

    // stage p holds: partial remainder, magnitude bits still to shift, quotient so far
    logic                 vld_reg  [DIV_W+1];
    logic [DIV_DEN_W-1:0] rem_reg  [DIV_W+1];
    logic [DIV_W-1:0]     nm_reg   [DIV_W+1];
    logic [DIV_DEN_W-1:0] dm_reg   [DIV_W+1];
    logic                 neg_reg  [DIV_W+1];
    logic [SIDE_W-1:0]    side_reg [DIV_W+1];

    logic [DIV_W-1:0]     num_mag;
    logic [DIV_DEN_W-1:0] den_mag;

    assign num_mag = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
    assign den_mag = den[DIV_DEN_W-1] ? DIV_DEN_W'(-den) : DIV_DEN_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        nm_reg[0]   <= num_mag;
        dm_reg[0]   <= den_mag;
        neg_reg[0]  <= num[DIV_W-1] ^ den[DIV_DEN_W-1];
        side_reg[0] <= side_in;
    end

    for (genvar p = 0; p < DIV_W; p++)
    begin : g_step
        logic [DIV_DEN_W:0]   trial;
        logic [DIV_DEN_W-1:0] rem_next;
        logic [DIV_W-1:0]     nm_next;

        always_comb
        begin
            trial = {rem_reg[p], nm_reg[p][DIV_W-1]} - {1'b0, dm_reg[p]};
            if (!trial[DIV_DEN_W])
            begin
                rem_next = trial[DIV_DEN_W-1:0];
                nm_next  = {nm_reg[p][DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[p][DIV_DEN_W-2:0], nm_reg[p][DIV_W-1]};
                nm_next  = {nm_reg[p][DIV_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[p+1] <= 1'b0;
            else
                vld_reg[p+1] <= vld_reg[p];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[p+1]  <= rem_next;
            nm_reg[p+1]   <= nm_next;
            dm_reg[p+1]   <= dm_reg[p];
            neg_reg[p+1]  <= neg_reg[p];
            side_reg[p+1] <= side_reg[p];
        end
    end

    assign out_valid = vld_reg[DIV_W];
    assign quo       = neg_reg[DIV_W] ? -$signed(nm_reg[DIV_W]) : $signed(nm_reg[DIV_W]);
    assign side_out  = side_reg[DIV_W];

endmodule

// ===== design/hcma_sqrt.sv =====
// hcma_sqrt: pipelined floor square root of a 64-bit value, two bits per stage
// depends on hcma_pkg; carries a side payload along

module hcma_sqrt
    import hcma_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [63:0]       rad,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [31:0]       root,
    output logic [SIDE_W-1:0] side_out
);

    logic              vld_reg  [SQ_STEPS+1];
    logic [65:0]       rem_reg  [SQ_STEPS+1];
    logic [63:0]       v_reg    [SQ_STEPS+1];
    logic [31:0]       q_reg    [SQ_STEPS+1];
    logic [SIDE_W-1:0] side_reg [SQ_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        v_reg[0]    <= rad;
        q_reg[0]    <= '0;
        side_reg[0] <= side_in;
    end

    for (genvar p = 0; p < SQ_STEPS; p++)
    begin : g_step
        logic [65:0] cur;
        logic [65:0] trial;
        logic [65:0] rem_next;
        logic [31:0] q_next;

        always_comb
        begin
            cur   = {rem_reg[p][63:0], v_reg[p][63:62]};
            trial = cur - {32'd0, q_reg[p], 2'b01};
            if (!trial[65])
            begin
                rem_next = trial;
                q_next   = {q_reg[p][30:0], 1'b1};
            end
            else
            begin
                rem_next = cur;
                q_next   = {q_reg[p][30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[p+1] <= 1'b0;
            else
                vld_reg[p+1] <= vld_reg[p];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[p+1]  <= rem_next;
            v_reg[p+1]    <= {v_reg[p][61:0], 2'b00};
            q_reg[p+1]    <= q_next;
            side_reg[p+1] <= side_reg[p];
        end
    end

    assign out_valid = vld_reg[SQ_STEPS];
    assign root      = q_reg[SQ_STEPS];
    assign side_out  = side_reg[SQ_STEPS];

endmodule
